/* rtl/adc_code_to_temperature_half_degree_top_macros.svh */
// assertion macros for the adc code to half-degree temperature block
`ifndef ADC_CODE_TO_TEMPERATURE_HALF_DEGREE_TOP_MACROS_SVH
`define ADC_CODE_TO_TEMPERATURE_HALF_DEGREE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define ACTHD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ACTHD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/acthd_pkg.sv */
// constants, segment tables and types for the adc code linearizer
`timescale 1ns / 1ps

package acthd_pkg;

    localparam int SLOPE_FRAC_BITS = 16;
    localparam int NUM_SEGS        = 13;
    localparam int SEG_IDX_W       = $clog2(NUM_SEGS);

    localparam int CODE_W   = 8;
    localparam int D_W      = 7;                       // largest offset into a segment is 65
    localparam int SLOPE_W  = SLOPE_FRAC_BITS + 4;     // slopes stay below 16 tenths per code
    localparam int PROD_W   = D_W + SLOPE_W;
    localparam int BASE_W   = 10;
    localparam int TENTHS_W = 11;
    localparam int WHOLE_W  = 7;
    localparam int DIGIT_W  = 4;
    localparam int TEMP_W   = 8;

    // tenths / 10 as a multiply by reciprocal, exact for tenths below 16384
    localparam int DIV10_MUL   = 6554;
    localparam int DIV10_MUL_W = 13;
    localparam int DIV10_SHIFT = 16;
    localparam int QPROD_W     = TENTHS_W + DIV10_MUL_W;
    localparam int DEC_RADIX   = 10;

    // tenths digit thresholds for the half-degree rounding
    localparam logic [DIGIT_W-1:0] DIGIT_HALF_MIN = DIGIT_W'(3);
    localparam logic [DIGIT_W-1:0] DIGIT_UP_MIN   = DIGIT_W'(8);

    localparam logic [TEMP_W-1:0] TEMP_MAX = TEMP_W'(240);

    typedef logic [SEG_IDX_W-1:0] seg_idx_t;

    localparam logic [CODE_W-1:0] SEG_START [NUM_SEGS] = '{
        8'd11, 8'd31, 8'd54, 8'd74, 8'd85, 8'd97, 8'd110,
        8'd116, 8'd125, 8'd165, 8'd173, 8'd186, 8'd190
    };

    localparam logic [BASE_W-1:0] SEG_BASE10 [NUM_SEGS] = '{
        10'd0, 10'd50, 10'd150, 10'd250, 10'd300, 10'd350, 10'd400,
        10'd500, 10'd600, 10'd750, 10'd800, 10'd900, 10'd916
    };

    // slope in tenths per code as num / den
    localparam logic [63:0] SEG_NUM [NUM_SEGS] = '{
        64'd1000000, 64'd4299966, 64'd4964000, 64'd4885700, 64'd4166670,
        64'd3846100, 64'd15669000, 64'd11140800, 64'd3713600, 64'd6325110,
        64'd8003200, 64'd3921500, 64'd4248860
    };

    localparam logic [63:0] SEG_DEN [NUM_SEGS] = '{
        64'd186982, 64'd1000000, 64'd1000000, 64'd1000000, 64'd1000000,
        64'd1000000, 64'd1000000, 64'd1000000, 64'd1000000, 64'd1000000,
        64'd1000000, 64'd1000000, 64'd1000000
    };

    // fixed-point slopes, rounded half up
    localparam logic [SLOPE_W-1:0] SEG_SLOPE [NUM_SEGS] = '{
        SLOPE_W'(((SEG_NUM[0]  << SLOPE_FRAC_BITS) + SEG_DEN[0]  / 2) / SEG_DEN[0]),
        SLOPE_W'(((SEG_NUM[1]  << SLOPE_FRAC_BITS) + SEG_DEN[1]  / 2) / SEG_DEN[1]),
        SLOPE_W'(((SEG_NUM[2]  << SLOPE_FRAC_BITS) + SEG_DEN[2]  / 2) / SEG_DEN[2]),
        SLOPE_W'(((SEG_NUM[3]  << SLOPE_FRAC_BITS) + SEG_DEN[3]  / 2) / SEG_DEN[3]),
        SLOPE_W'(((SEG_NUM[4]  << SLOPE_FRAC_BITS) + SEG_DEN[4]  / 2) / SEG_DEN[4]),
        SLOPE_W'(((SEG_NUM[5]  << SLOPE_FRAC_BITS) + SEG_DEN[5]  / 2) / SEG_DEN[5]),
        SLOPE_W'(((SEG_NUM[6]  << SLOPE_FRAC_BITS) + SEG_DEN[6]  / 2) / SEG_DEN[6]),
        SLOPE_W'(((SEG_NUM[7]  << SLOPE_FRAC_BITS) + SEG_DEN[7]  / 2) / SEG_DEN[7]),
        SLOPE_W'(((SEG_NUM[8]  << SLOPE_FRAC_BITS) + SEG_DEN[8]  / 2) / SEG_DEN[8]),
        SLOPE_W'(((SEG_NUM[9]  << SLOPE_FRAC_BITS) + SEG_DEN[9]  / 2) / SEG_DEN[9]),
        SLOPE_W'(((SEG_NUM[10] << SLOPE_FRAC_BITS) + SEG_DEN[10] / 2) / SEG_DEN[10]),
        SLOPE_W'(((SEG_NUM[11] << SLOPE_FRAC_BITS) + SEG_DEN[11] / 2) / SEG_DEN[11]),
        SLOPE_W'(((SEG_NUM[12] << SLOPE_FRAC_BITS) + SEG_DEN[12] / 2) / SEG_DEN[12])
    };

endpackage

/* rtl/adc_code_to_temperature_half_degree_top.sv */
// Converts an 8-bit sensor ADC code to temperature in half-degree units through
// 13 linear segments, rounding the tenths digit to the nearest half degree.
// Codes below 11 give 0 with the under_range flag (m_tuser) set. The block takes
// one request per clock while back-pressure leaves room, and passes each result
// through its five register stages: segment select, slope multiply, base add,
// divide by ten, rounding. Each stage holds its own item under back-pressure,
// so empty stages keep filling while m_tready is low.
`timescale 1ns / 1ps

`include "adc_code_to_temperature_half_degree_top_macros.svh"

module adc_code_to_temperature_half_degree_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [acthd_pkg::CODE_W-1:0]  s_tdata,   // [7:0] adc_code
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [acthd_pkg::TEMP_W-1:0]  m_tdata,   // [7:0] temp_half_deg
    output logic                          m_tuser    // [0] under_range
);

    import acthd_pkg::*;

    // valid bits
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // stage payloads
    seg_idx_t                s1_seg_reg, s1_seg_next;
    logic [D_W-1:0]          s1_d_reg, s1_d_next;
    logic                    s1_und_reg, s1_und_next;

    logic [TENTHS_W-1:0]     s2_ofs_reg, s2_ofs_next;
    logic [BASE_W-1:0]       s2_base_reg, s2_base_next;
    logic                    s2_und_reg;

    logic [TENTHS_W-1:0]     s3_tenths_reg, s3_tenths_next;
    logic                    s3_und_reg;

    logic [TENTHS_W-1:0]     s4_tenths_reg;
    logic [WHOLE_W-1:0]      s4_whole_reg, s4_whole_next;
    logic                    s4_und_reg;

    logic [TEMP_W-1:0]       s5_temp_reg, s5_temp_next;
    logic                    s5_und_reg;

    logic [PROD_W-1:0]       prod;
    logic [QPROD_W-1:0]      qprod;
    logic [DIGIT_W-1:0]      digit;
    logic [TEMP_W-1:0]       twice;

    // per-stage ready, a stage loads when it is empty or its content moves on
    assign rdy5     = !s5_vld_reg || m_tready;
    assign rdy4     = !s4_vld_reg || rdy5;
    assign rdy3     = !s3_vld_reg || rdy4;
    assign rdy2     = !s2_vld_reg || rdy3;
    assign rdy1     = !s1_vld_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) s1_vld_reg <= s_tvalid;
            if (rdy2) s2_vld_reg <= s1_vld_reg;
            if (rdy3) s3_vld_reg <= s2_vld_reg;
            if (rdy4) s4_vld_reg <= s3_vld_reg;
            if (rdy5) s5_vld_reg <= s4_vld_reg;
        end
    end

    // stage 1: segment select by breakpoint
    always_comb
    begin
        s1_seg_next = '0;
        for (int i = 1; i < NUM_SEGS; i++)
        begin
            if (s_tdata >= SEG_START[i])
                s1_seg_next = SEG_IDX_W'(i);
        end
        s1_d_next   = D_W'(s_tdata - SEG_START[s1_seg_next]);
        s1_und_next = (s_tdata < SEG_START[0]);
    end

    // stage 2: offset times slope, fraction below one tenth dropped
    always_comb
    begin
        prod         = PROD_W'(s1_d_reg) * PROD_W'(SEG_SLOPE[s1_seg_reg]);
        s2_ofs_next  = prod[SLOPE_FRAC_BITS +: TENTHS_W];
        s2_base_next = SEG_BASE10[s1_seg_reg];
    end

    // stage 3: add the segment base
    assign s3_tenths_next = TENTHS_W'(s2_base_reg) + s2_ofs_reg;

    // stage 4: whole degrees by reciprocal multiply
    always_comb
    begin
        qprod         = QPROD_W'(s3_tenths_reg) * QPROD_W'(DIV10_MUL);
        s4_whole_next = qprod[DIV10_SHIFT +: WHOLE_W];
    end

    // stage 5: tenths digit rounds to a half degree
    always_comb
    begin
        digit = DIGIT_W'(s4_tenths_reg - TENTHS_W'(s4_whole_reg) * TENTHS_W'(DEC_RADIX));
        twice = {s4_whole_reg, 1'b0};
        if (s4_und_reg)
            s5_temp_next = '0;
        else if (digit >= DIGIT_UP_MIN)
            s5_temp_next = twice + TEMP_W'(2);
        else if (digit >= DIGIT_HALF_MIN)
            s5_temp_next = twice + TEMP_W'(1);
        else
            s5_temp_next = twice;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && s_tvalid)
        begin
            s1_seg_reg <= s1_seg_next;
            s1_d_reg   <= s1_d_next;
            s1_und_reg <= s1_und_next;
        end
        if (rdy2 && s1_vld_reg)
        begin
            s2_ofs_reg  <= s2_ofs_next;
            s2_base_reg <= s2_base_next;
            s2_und_reg  <= s1_und_reg;
        end
        if (rdy3 && s2_vld_reg)
        begin
            s3_tenths_reg <= s3_tenths_next;
            s3_und_reg    <= s2_und_reg;
        end
        if (rdy4 && s3_vld_reg)
        begin
            s4_tenths_reg <= s3_tenths_reg;
            s4_whole_reg  <= s4_whole_next;
            s4_und_reg    <= s3_und_reg;
        end
        if (rdy5 && s4_vld_reg)
        begin
            s5_temp_reg <= s5_temp_next;
            s5_und_reg  <= s4_und_reg;
        end
    end

    assign m_tvalid = s5_vld_reg;
    assign m_tdata  = s5_temp_reg;
    assign m_tuser  = s5_und_reg;

    `ACTHD_ASSERT_NEXT(a_accept_fills_s1, s_tvalid && s_tready, s1_vld_reg, "accepted request did not reach stage 1")
    `ACTHD_ASSERT_NEXT(a_stall_keeps_s4, s4_vld_reg && !rdy5, s4_vld_reg, "stalled item dropped from stage 4")
    `ACTHD_ASSERT_NOW(a_under_is_zero, m_tvalid && m_tuser, m_tdata == '0, "under-range result not saturated")
    `ACTHD_ASSERT_NOW(a_temp_in_range, m_tvalid, m_tdata <= TEMP_MAX, "temperature above range")

endmodule

/* sim/adc_temp_checker.sv */
// checker: predicts the half-degree temperature of each adc code and matches the block output
`timescale 1ns / 1ps

module adc_temp_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [acthd_pkg::CODE_W-1:0] s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [acthd_pkg::TEMP_W-1:0] m_tdata,
    input  logic                         m_tuser,
    output int                           error_count,
    output int                           in_flight
);

    import acthd_pkg::*;

    localparam int NUM_PIECES   = 13;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed
    {
        logic [TEMP_W-1:0] temp_half_deg;
        logic              under_range;
    } reading_t;

    reading_t expected_readings [$];
    int       errs = 0;

    // breakpoint, base in tenths and slope in tenths per code as num / den
    function automatic void piece_info(input int k, output int unsigned first,
                                       output int unsigned base10,
                                       output longint unsigned num,
                                       output longint unsigned den);
        den = 64'd1000000;
        case (k)
            0:
            begin
                first = 11;  base10 = 0;   num = 64'd1000000; den = 64'd186982;
            end
            1:  begin first = 31;  base10 = 50;  num = 64'd4299966;  end
            2:  begin first = 54;  base10 = 150; num = 64'd4964000;  end
            3:  begin first = 74;  base10 = 250; num = 64'd4885700;  end
            4:  begin first = 85;  base10 = 300; num = 64'd4166670;  end
            5:  begin first = 97;  base10 = 350; num = 64'd3846100;  end
            6:  begin first = 110; base10 = 400; num = 64'd15669000; end
            7:  begin first = 116; base10 = 500; num = 64'd11140800; end
            8:  begin first = 125; base10 = 600; num = 64'd3713600;  end
            9:  begin first = 165; base10 = 750; num = 64'd6325110;  end
            10: begin first = 173; base10 = 800; num = 64'd8003200;  end
            11: begin first = 186; base10 = 900; num = 64'd3921500;  end
            default:
            begin
                first = 190; base10 = 916; num = 64'd4248860;
            end
        endcase
    endfunction

    function automatic reading_t linearize(input logic [CODE_W-1:0] code);
        reading_t          r;
        int unsigned       first;
        int unsigned       base10;
        longint unsigned   num;
        longint unsigned   den;
        longint unsigned   slope;
        longint unsigned   tenths;
        longint unsigned   whole;
        longint unsigned   digit;
        longint unsigned   half;
        int                piece;

        piece_info(0, first, base10, num, den);
        if (code < first)
        begin
            r.temp_half_deg = '0;
            r.under_range   = 1'b1;
            return r;
        end
        piece = 0;
        for (int k = 1; k < NUM_PIECES; k++)
        begin
            piece_info(k, first, base10, num, den);
            if (code >= first)
                piece = k;
        end
        piece_info(piece, first, base10, num, den);
        slope  = ((num << SLOPE_FRAC_BITS) + den / 2) / den;
        tenths = base10 + (((code - first) * slope) >> SLOPE_FRAC_BITS);
        whole  = tenths / 10;
        digit  = tenths % 10;
        // tenths digit 0-2 rounds down, 3-7 lands on .5, 8-9 rounds up
        if (digit < 3)
            half = whole * 2;
        else if (digit <= 7)
            half = whole * 2 + 1;
        else
            half = whole * 2 + 2;
        r.temp_half_deg = half[TEMP_W-1:0];
        r.under_range   = 1'b0;
        return r;
    endfunction

    always @(posedge clk)
    begin
        reading_t want;

        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_readings.push_back(linearize(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (expected_readings.size() == 0)
                begin
                    if (errs < REPORT_LIMIT)
                        $display("%0t: unexpected result temp=%0d under_range=%0b",
                                 $realtime, m_tdata, m_tuser);
                    errs++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (m_tdata !== want.temp_half_deg || m_tuser !== want.under_range)
                    begin
                        if (errs < REPORT_LIMIT)
                            $display({"%0t: expected temp=%0d under_range=%0b, ",
                                      "got temp=%0d under_range=%0b"},
                                     $realtime, want.temp_half_deg, want.under_range,
                                     m_tdata, m_tuser);
                        errs++;
                    end
                end
            end
            error_count <= errs;
            in_flight   <= expected_readings.size();
        end
    end

endmodule

/* sim/tb_adc_code_to_temperature_half_degree_top.sv */
// testbench top: drives adc codes with random gaps and back-pressure and gives the verdict
`timescale 1ns / 1ps

module tb_adc_code_to_temperature_half_degree_top;
    import acthd_pkg::*;

    localparam int RANDOM_CODES = 950;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 12;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [CODE_W-1:0] s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [TEMP_W-1:0] m_tdata;
    logic              m_tuser;
    int                error_count;
    int                in_flight;
    int                idle_cycles = 0;

    // breakpoints, the codes just below some of them and both ends of the code range
    logic [CODE_W-1:0] corner_codes [21] = '{
        8'd0, 8'd10, 8'd11, 8'd30, 8'd31, 8'd53, 8'd54, 8'd74, 8'd85, 8'd97,
        8'd109, 8'd110, 8'd116, 8'd125, 8'd165, 8'd173, 8'd186, 8'd189, 8'd190,
        8'd254, 8'd255
    };

    adc_code_to_temperature_half_degree_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    adc_temp_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .error_count (error_count),
        .in_flight   (in_flight)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // mostly short pauses, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_code(input logic [CODE_W-1:0] code);
        s_tvalid = 1'b1;
        s_tdata  = code;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic maybe_pause(input bit steady);
        int gap;

        if (!steady && $urandom_range(0, 1) == 0)
        begin
            gap      = pick_gap();
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // receiver back-pressure, with calm stretches that start no new stalls
    initial
    begin
        int  stall_left;
        int  cycle_n;
        bit  calm;

        stall_left = 0;
        cycle_n    = 0;
        calm       = 1'b0;
        m_tready   = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (cycle_n % 128 == 0)
                calm = ($urandom_range(0, 3) == 0);
            cycle_n++;
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready = 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        bit steady;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (corner_codes[i])
        begin
            send_code(corner_codes[i]);
            maybe_pause(1'b0);
        end

        steady = 1'b0;
        for (int n = 0; n < RANDOM_CODES; n++)
        begin
            if (n % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            send_code(CODE_W'($urandom_range(0, 255)));
            maybe_pause(steady);
        end
        s_tvalid = 1'b0;

        while (in_flight != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
